// ----- rtl/stwl_pkg.sv -----
// Shared constants and types for the stage transition window labeler.
// Used by the label store, the top level and the port checker.
`default_nettype none

package stwl_pkg;

  // Window and store sizing.
  localparam int MAX_WINDOW = 32;
  localparam int DEPTH      = 2 * MAX_WINDOW;
  localparam int WIN_W      = 6;
  localparam int CNT_W      = $clog2(DEPTH) + 1;
  localparam int LAB_W      = 7;
  localparam int STAGE_W    = 2;

  localparam logic [WIN_W-1:0] DEFAULT_WINDOW = WIN_W'(6);
  localparam logic [WIN_W-1:0] RUN_SAT        = WIN_W'(63);

  // Stage codes.
  localparam logic [STAGE_W-1:0] STAGE_NREM   = 2'd1;
  localparam logic [STAGE_W-1:0] STAGE_REM    = 2'd2;
  localparam logic [STAGE_W-1:0] STAGE_IGNORE = 2'd3;

  typedef logic signed [LAB_W-1:0] label_t;

  // One stored epoch: a label for each kind of boundary.
  typedef struct packed {
    label_t nr_to_r;
    label_t r_to_nr;
  } label_pair_t;

  // Per-cycle commands from the top level to the label store.
  typedef struct packed {
    logic             pop;
    logic             push;
    logic             mark_nr;
    logic             mark_rn;
    logic [CNT_W-1:0] fill;
    logic [WIN_W-1:0] win;
  } store_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/stwl_label_store.sv -----
// Shifting label store: the oldest epoch sits at position zero.
// Handles pop, push of a cleared epoch and the parallel window marking. Uses stwl_pkg.
`default_nettype none

module stwl_label_store (
  input  wire logic                 clk_i,
  input  wire stwl_pkg::store_ctrl_t ctrl_i,
  output      stwl_pkg::label_pair_t head_o
);
  import stwl_pkg::*;

  label_pair_t entry_q [DEPTH];
  label_pair_t entry_d [DEPTH];
  label_pair_t shifted [DEPTH];

  // Entries move down by one when the head is taken.
  always_comb begin
    for (int i = 0; i < DEPTH - 1; i++) begin
      shifted[i] = ctrl_i.pop ? entry_q[i+1] : entry_q[i];
    end
    shifted[DEPTH-1] = ctrl_i.pop ? '0 : entry_q[DEPTH-1];
  end

  // Clear the new epoch's slot, then write the window labels around a boundary.
  always_comb begin
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] k;
    logic [CNT_W-1:0] w_ext;
    logic [CNT_W-1:0] span;
    logic [CNT_W-1:0] lab;
    logic             in_win;
    w_ext = {1'b0, ctrl_i.win};
    span  = {ctrl_i.win, 1'b0};
    for (int i = 0; i < DEPTH; i++) begin
      pos        = CNT_W'(i);
      k          = ctrl_i.fill - CNT_W'(1) - pos;
      in_win     = (pos < ctrl_i.fill) && (k < span);
      lab        = (k < w_ext) ? (w_ext - k) : (w_ext - k - CNT_W'(1));
      entry_d[i] = shifted[i];
      if (ctrl_i.push && (pos == ctrl_i.fill - CNT_W'(1))) begin
        entry_d[i] = '0;
      end
      if (ctrl_i.mark_nr && in_win) begin
        entry_d[i].nr_to_r = label_t'(lab);
      end
      if (ctrl_i.mark_rn && in_win) begin
        entry_d[i].r_to_nr = label_t'(lab);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      entry_q[i] <= entry_d[i];
    end
  end

  assign head_o = entry_q[0];

endmodule

`default_nettype wire

// ----- rtl/stage_transition_window_labeler.sv -----
// Top level of the stage transition window labeler: run tracking, flow control
// and the result register. Uses stwl_pkg and stwl_label_store.
`default_nettype none

// How to use this block:
// The input channel takes one stage code per epoch with a last-epoch flag.
// The output channel gives one result per epoch, oldest first: two signed
// labels and a flag set on the result of the final epoch of a record.
// The window length register is written through cfg_we_i and cfg_wdata_i
// while the block is idle; it resets to 6 and values above 32 act as 32.
// Throughput is one item per cycle while in_stall_o is low. An epoch's result
// is released by the item that arrives 2W-1 epochs after it; that item is
// registered in the owed count, then the epoch moves to the output register.
// A window below two gives a delay of one epoch. A last-epoch item releases
// every stored epoch, up to 64 of them: they drain one per cycle while the
// receiver does not stall, and in_stall_o stays high until the last one has
// moved to the output register. A smaller window written between items takes
// effect with the next item, which then releases the surplus in the same way.
// When the receiver stalls, the result register holds; items are still taken
// until one of them owes a result, and then in_stall_o rises.
// Reset clears the runs, the counts and the output valid; the window
// register returns to 6. Stored labels need no reset.
module stage_transition_window_labeler (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [stwl_pkg::WIN_W-1:0]   cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic [stwl_pkg::STAGE_W-1:0] stage_code_i,
  input  wire logic                         last_epoch_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic signed [stwl_pkg::LAB_W-1:0] nrem_to_rem_label_o,
  output      logic signed [stwl_pkg::LAB_W-1:0] rem_to_nrem_label_o,
  output      logic                         last_result_o
);
  import stwl_pkg::*;

  logic [WIN_W-1:0]   window_q;
  logic [WIN_W-1:0]   run_len_q, run_len_d, before_len_q, before_len_d;
  logic [STAGE_W-1:0] run_stage_q, run_stage_d, before_stage_q, before_stage_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d, owed_q, owed_d;
  logic               flush_q, flush_d;
  logic               out_valid_q, out_valid_d;
  label_t             nr_lab_q, rn_lab_q;
  logic               last_q;

  logic               pop, accept, final_pop, qualified;
  logic [CNT_W-1:0]   fill, delay;
  logic [WIN_W-1:0]   w_eff;
  logic [WIN_W-1:0]   upd_len, upd_before_len;
  logic [STAGE_W-1:0] upd_stage, upd_before_stage;
  store_ctrl_t        ctrl;
  label_pair_t        head;

  // Window clamp and emission delay.
  assign w_eff = (window_q > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : window_q;
  assign delay = (w_eff < WIN_W'(1)) ? CNT_W'(1) : ({w_eff, 1'b0} - CNT_W'(1));

  // One epoch leaves the store whenever one is owed and the result register is free.
  assign pop        = (owed_q != '0) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (owed_q != {{(CNT_W-1){1'b0}}, pop});
  assign accept     = in_valid_i && !in_stall_o;
  assign fill       = cnt_q - {{(CNT_W-1){1'b0}}, pop} + CNT_W'(1);
  assign final_pop  = flush_q && (cnt_q == CNT_W'(1));

  // Run tracking for the new epoch.
  always_comb begin
    upd_len          = run_len_q;
    upd_stage        = run_stage_q;
    upd_before_len   = before_len_q;
    upd_before_stage = before_stage_q;
    if (stage_code_i == run_stage_q) begin
      if (run_len_q < RUN_SAT) begin
        upd_len = run_len_q + WIN_W'(1);
      end
    end else begin
      upd_before_stage = run_stage_q;
      upd_before_len   = run_len_q;
      upd_stage        = stage_code_i;
      upd_len          = WIN_W'(1);
    end
  end

  assign qualified = accept && (w_eff >= WIN_W'(2)) && (upd_len == w_eff) &&
                     (upd_before_len >= w_eff);

  // Commands to the label store.
  always_comb begin
    ctrl.pop     = pop;
    ctrl.push    = accept;
    ctrl.mark_nr = qualified && (upd_stage == STAGE_REM) && (upd_before_stage == STAGE_NREM);
    ctrl.mark_rn = qualified && (upd_stage == STAGE_NREM) && (upd_before_stage == STAGE_REM);
    ctrl.fill    = fill;
    ctrl.win     = w_eff;
  end

  stwl_label_store u_store (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .head_o (head)
  );

  // Next state of the runs, counts and flush flag.
  always_comb begin
    run_len_d      = run_len_q;
    run_stage_d    = run_stage_q;
    before_len_d   = before_len_q;
    before_stage_d = before_stage_q;
    cnt_d          = cnt_q - {{(CNT_W-1){1'b0}}, pop};
    owed_d         = owed_q - {{(CNT_W-1){1'b0}}, pop};
    flush_d        = flush_q && !(pop && final_pop);
    if (accept) begin
      cnt_d = fill;
      if (last_epoch_i) begin
        run_len_d      = '0;
        run_stage_d    = STAGE_IGNORE;
        before_len_d   = '0;
        before_stage_d = STAGE_IGNORE;
        owed_d         = fill;
        flush_d        = 1'b1;
      end else begin
        run_len_d      = upd_len;
        run_stage_d    = upd_stage;
        before_len_d   = upd_before_len;
        before_stage_d = upd_before_stage;
        owed_d         = (fill > delay) ? (fill - delay) : '0;
      end
    end
  end

  // The result register holds while stalled.
  assign out_valid_d = pop || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q       <= DEFAULT_WINDOW;
      run_len_q      <= '0;
      run_stage_q    <= STAGE_IGNORE;
      before_len_q   <= '0;
      before_stage_q <= STAGE_IGNORE;
      cnt_q          <= '0;
      owed_q         <= '0;
      flush_q        <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      run_len_q      <= run_len_d;
      run_stage_q    <= run_stage_d;
      before_len_q   <= before_len_d;
      before_stage_q <= before_stage_d;
      cnt_q          <= cnt_d;
      owed_q         <= owed_d;
      flush_q        <= flush_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      nr_lab_q <= head.nr_to_r;
      rn_lab_q <= head.r_to_nr;
      last_q   <= final_pop;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign nrem_to_rem_label_o = nr_lab_q;
  assign rem_to_nrem_label_o = rn_lab_q;
  assign last_result_o       = last_q;

endmodule

`default_nettype wire

// ----- rtl/stwl_checker.sv -----
// Port-level checks for the stage transition window labeler.
// Bound to the top level below; uses stwl_pkg for widths.
`default_nettype none

module stwl_assert (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic signed [stwl_pkg::LAB_W-1:0] nrem_to_rem_label_o,
  input wire logic signed [stwl_pkg::LAB_W-1:0] rem_to_nrem_label_o,
  input wire logic                         last_result_o
);
  import stwl_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(nrem_to_rem_label_o) &&
    $stable(rem_to_nrem_label_o) && $stable(last_result_o))
    else $error("stalled result changed");

  // Labels never exceed the largest window.
  a_label_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (nrem_to_rem_label_o >= -label_t'(MAX_WINDOW)) &&
    (nrem_to_rem_label_o <= label_t'(MAX_WINDOW)) &&
    (rem_to_nrem_label_o >= -label_t'(MAX_WINDOW)) &&
    (rem_to_nrem_label_o <= label_t'(MAX_WINDOW)))
    else $error("label outside the window span");

  // A valid result carries known values.
  a_known_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown({nrem_to_rem_label_o, rem_to_nrem_label_o, last_result_o}))
    else $error("result with unknown bits");

  // A stalled input stays stalled while the receiver holds off.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && out_valid_o && out_stall_i ##1 out_stall_i |-> in_stall_o)
    else $error("input released while no result could leave");

endmodule

bind stage_transition_window_labeler stwl_assert u_stwl_assert (.*);

`default_nettype wire
